// File: hdl/ale_pkg.sv
// ============================================================================
// ale_pkg
// Shared types, codes and sizing for the array list engine.
// ============================================================================
package ale_pkg;

    // List capacity and the widths that follow from it.
    localparam int CAPACITY = 32;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths of the beats.
    localparam int CMD_W    = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 6;

    // Common width for comparing positions against the count.
    localparam int CMP_A    = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;
    localparam int CMP_W    = (CMP_A > COUNT_W) ? CMP_A : COUNT_W;

    localparam logic [CMP_W-1:0] CAP_X   = CMP_W'(CAPACITY);
    localparam logic [CMP_W-1:0] ONE_X   = CMP_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_ZERO = '0;
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } cmd_beat_t;

    typedef struct packed {
        logic                     accepted;
        logic signed [DATA_W-1:0] item;
        logic [POS_W-1:0]         next_position;
        logic                     next_exists;
        logic [COUNT_W-1:0]       count;
    } rsp_beat_t;

    // Request from the control logic to the shift sequencer.
    typedef struct packed {
        logic              go;
        logic              up;
        logic [ADDR_W-1:0] first;
        logic [CNT_W-1:0]  moves;
    } shift_req_t;

    // Memory port requests and status from the shift sequencer.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              busy;
    } shift_ctrl_t;

    function automatic logic [CMP_W-1:0] ext_cnt(input logic [CNT_W-1:0] c);
        return CMP_W'(c);
    endfunction

    function automatic logic [CMP_W-1:0] ext_pos(input logic [POS_W-1:0] p);
        return CMP_W'(p);
    endfunction

endpackage

// File: hdl/ale_shift_seq.sv
// ============================================================================
// ale_shift_seq
// Moves a run of list entries by one place, one entry per cycle, through
// a memory with registered read data.
// ============================================================================
module ale_shift_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ale_pkg::shift_req_t  req,
    output ale_pkg::shift_ctrl_t ctrl
);

    logic [ale_pkg::ADDR_W-1:0] src_reg;
    logic [ale_pkg::CNT_W-1:0]  left_reg;
    logic                       up_reg;
    logic                       wr_pend_reg;
    logic [ale_pkg::ADDR_W-1:0] wr_addr_reg;
    logic                       rd_go;

    // A source entry is read while moves remain; its data is written in the
    // next cycle to the neighbor in the direction of the shift.
    assign rd_go = (left_reg != ale_pkg::CNT_ZERO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg     <= '0;
            left_reg    <= '0;
            up_reg      <= 1'b0;
            wr_pend_reg <= 1'b0;
            wr_addr_reg <= '0;
        end
        else if (req.go)
        begin
            src_reg     <= req.first;
            left_reg    <= req.moves;
            up_reg      <= req.up;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= rd_go;
            if (rd_go)
            begin
                left_reg    <= left_reg - ale_pkg::CNT_ONE;
                wr_addr_reg <= up_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                src_reg     <= up_reg ? src_reg - 1'b1 : src_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        ctrl.rd_en   = rd_go;
        ctrl.rd_addr = src_reg;
        ctrl.wr_en   = wr_pend_reg;
        ctrl.wr_addr = wr_addr_reg;
        ctrl.busy    = rd_go || wr_pend_reg;
    end

endmodule

// File: hdl/array_list_engine.sv
// ============================================================================
// array_list_engine
// Fixed-capacity ordered list of 32-bit entries kept in an on-chip memory,
// with clear, append, insert, delete and read commands.
// ============================================================================
//
//  Channel | Signals                      | Beat
//  --------+------------------------------+----------------------------------
//  cmd     | cmd_valid, cmd_ready, cmd    | command, position, value
//  rsp     | rsp_valid, rsp_ready, rsp    | accepted, item, next_position,
//          |                              | next_exists, count
//
//  One command is in flight at a time. A short command (clear, append, read,
//  rejected or unknown) passes through the run and finish steps before it
//  raises rsp_valid and cmd_ready; an accepted insert or delete also waits
//  in the shift step while the memory moves one entry per cycle, and an
//  insert then writes its value. Reset clears count and control state, not
//  the memory; a stalled response holds off the next command.
//
module array_list_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  ale_pkg::cmd_beat_t  cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ale_pkg::rsp_beat_t  rsp
);

    // Control states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0] state_reg, state_next;

    // The command being worked on.
    logic [ale_pkg::CMD_W-1:0]  cmd_reg;
    logic [ale_pkg::POS_W-1:0]  pos_reg;
    logic [ale_pkg::DATA_W-1:0] val_reg;

    // Element count and the parts of the response settled in the run step.
    logic [ale_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       acc_reg, acc_next;
    logic                       has_next_reg, has_next_next;
    logic [ale_pkg::POS_W-1:0]  nxt_reg, nxt_next;
    logic                       rd_item_reg, rd_item_next;

    // Response output register.
    logic                       rsp_valid_reg, rsp_valid_next;
    ale_pkg::rsp_beat_t         rsp_reg, rsp_next;

    // List memory: one write port and one read port, read data registered.
    logic [ale_pkg::DATA_W-1:0] mem [ale_pkg::CAPACITY];
    logic [ale_pkg::DATA_W-1:0] rdata_reg;
    logic                       mem_wr_en;
    logic [ale_pkg::ADDR_W-1:0] mem_wr_addr;
    logic [ale_pkg::DATA_W-1:0] mem_wr_data;
    logic                       mem_rd_en;
    logic [ale_pkg::ADDR_W-1:0] mem_rd_addr;

    // Direct memory accesses from the control logic.
    logic                       top_wr_en;
    logic [ale_pkg::ADDR_W-1:0] top_wr_addr;
    logic                       top_rd_en;

    ale_pkg::shift_req_t        shift_req;
    ale_pkg::shift_ctrl_t       shift_ctrl;

    // Position and count brought to a common width for the bound checks.
    logic [ale_pkg::CMP_W-1:0]  pos_x, cnt_x, pos_inc_x, cnt_dec_x;
    logic [ale_pkg::CMP_W-1:0]  ins_moves_x, del_moves_x;
    logic                       in_range, full, slot_free;

    assign pos_x       = ale_pkg::ext_pos(pos_reg);
    assign cnt_x       = ale_pkg::ext_cnt(count_reg);
    assign pos_inc_x   = pos_x + ale_pkg::ONE_X;
    assign cnt_dec_x   = cnt_x - ale_pkg::ONE_X;
    assign ins_moves_x = cnt_x - pos_x;
    assign del_moves_x = cnt_dec_x - pos_x;
    assign in_range    = (pos_x < cnt_x);
    assign full        = (cnt_x == ale_pkg::CAP_X);

    // The output register can take a new beat when empty or being drained.
    assign slot_free   = !rsp_valid_reg || rsp_ready;

    assign cmd_ready   = (state_reg == ST_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign rsp         = rsp_reg;

    ale_shift_seq u_shift (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (shift_req),
        .ctrl  (shift_ctrl)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        has_next_next  = has_next_reg;
        nxt_next       = nxt_reg;
        rd_item_next   = rd_item_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        top_wr_en      = 1'b0;
        top_wr_addr    = count_reg[ale_pkg::ADDR_W-1:0];
        top_rd_en      = 1'b0;
        shift_req.go    = 1'b0;
        shift_req.up    = 1'b0;
        shift_req.first = cnt_dec_x[ale_pkg::ADDR_W-1:0];
        shift_req.moves = ins_moves_x[ale_pkg::CNT_W-1:0];

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_RUN;
                end
            end

            ST_RUN:
            begin
                // Bounds are checked here; the count takes its new value
                // at once, since later steps only use the latched inputs.
                acc_next      = 1'b0;
                has_next_next = 1'b0;
                nxt_next      = '0;
                rd_item_next  = 1'b0;
                state_next    = ST_FIN;
                unique case (cmd_reg)
                    ale_pkg::CMD_CLEAR:
                    begin
                        acc_next   = 1'b1;
                        count_next = ale_pkg::CNT_ZERO;
                    end
                    ale_pkg::CMD_APPEND:
                    begin
                        if (!full)
                        begin
                            acc_next   = 1'b1;
                            top_wr_en  = 1'b1;
                            count_next = count_reg + ale_pkg::CNT_ONE;
                        end
                    end
                    ale_pkg::CMD_INSERT:
                    begin
                        if (in_range && !full)
                        begin
                            acc_next        = 1'b1;
                            count_next      = count_reg + ale_pkg::CNT_ONE;
                            shift_req.go    = 1'b1;
                            shift_req.up    = 1'b1;
                            state_next      = ST_SHIFT;
                        end
                    end
                    ale_pkg::CMD_DELETE:
                    begin
                        if (in_range)
                        begin
                            acc_next        = 1'b1;
                            count_next      = count_reg - ale_pkg::CNT_ONE;
                            shift_req.go    = 1'b1;
                            shift_req.up    = 1'b0;
                            shift_req.first = pos_inc_x[ale_pkg::ADDR_W-1:0];
                            shift_req.moves = del_moves_x[ale_pkg::CNT_W-1:0];
                            state_next      = ST_SHIFT;
                        end
                    end
                    ale_pkg::CMD_READ:
                    begin
                        if (in_range)
                        begin
                            acc_next     = 1'b1;
                            rd_item_next = 1'b1;
                            top_rd_en    = 1'b1;
                            if (pos_inc_x < cnt_x)
                            begin
                                has_next_next = 1'b1;
                                nxt_next      = pos_reg + ale_pkg::POS_ONE;
                            end
                        end
                    end
                    default:
                    begin
                        // Unknown commands leave everything as it is.
                    end
                endcase
            end

            ST_SHIFT:
            begin
                // Once the last move is written, an insert drops the new
                // value into the hole it opened.
                if (!shift_ctrl.busy)
                begin
                    if (cmd_reg == ale_pkg::CMD_INSERT)
                    begin
                        top_wr_en   = 1'b1;
                        top_wr_addr = pos_x[ale_pkg::ADDR_W-1:0];
                    end
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (slot_free)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_next.accepted      = acc_reg;
                    rsp_next.item          = rd_item_reg ? rdata_reg : '0;
                    rsp_next.next_position = nxt_reg;
                    rsp_next.next_exists   = has_next_reg;
                    rsp_next.count         = cnt_x[ale_pkg::COUNT_W-1:0];
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory port selection: the sequencer owns both ports while it runs.
    always_comb
    begin
        mem_wr_en   = shift_ctrl.wr_en || top_wr_en;
        mem_wr_addr = shift_ctrl.wr_en ? shift_ctrl.wr_addr : top_wr_addr;
        mem_wr_data = shift_ctrl.wr_en ? rdata_reg : val_reg;
        mem_rd_en   = shift_ctrl.rd_en || top_rd_en;
        mem_rd_addr = shift_ctrl.rd_en ? shift_ctrl.rd_addr
                                       : pos_x[ale_pkg::ADDR_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rdata_reg <= mem[mem_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= cmd.command;
            pos_reg <= cmd.position;
            val_reg <= cmd.value;
        end
        acc_reg      <= acc_next;
        has_next_reg <= has_next_next;
        nxt_reg      <= nxt_next;
        rd_item_reg  <= rd_item_next;
        rsp_reg      <= rsp_next;
    end

    // The count never goes beyond the capacity of the list.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_x <= ale_pkg::CAP_X)
        else $error("list count above capacity");

    // The shift sequencer is quiet whenever a new command can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !shift_ctrl.busy)
        else $error("shift still running while idle");

    // Direct writes never collide with a write from the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        shift_ctrl.wr_en |-> !top_wr_en)
        else $error("memory write port conflict");

    // A command beat always leads into the run step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |=> (state_reg == ST_RUN))
        else $error("command beat not executed");

    // A response is loaded only into a free output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> $stable(rsp))
        else $error("pending response overwritten");

endmodule
